FILE: src/utf8_vietnamese_to_ascii_top_macros.svh
// assertion macros for the utf-8 vietnamese to ascii block
// used by utf8_vietnamese_to_ascii_top; no other dependencies
`ifndef UTF8_VIETNAMESE_TO_ASCII_TOP_MACROS_SVH
`define UTF8_VIETNAMESE_TO_ASCII_TOP_MACROS_SVH
`ifndef SYNTHESIS
// antecedent and consequent in the same cycle
`define U8VA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8va assertion failed");
// consequent in the cycle after the antecedent
`define U8VA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8va assertion failed");
`else
`define U8VA_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define U8VA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: src/u8va_pkg.sv
// shared types, constants and character mapping functions
// used by every module of the utf-8 vietnamese to ascii block
`default_nettype none
package u8va_pkg;

  localparam int QueueDepthDefault = 4;

  localparam logic [7:0] LeadC3 = 8'hC3;
  localparam logic [7:0] LeadC4 = 8'hC4;
  localparam logic [7:0] LeadC6 = 8'hC6;
  localparam logic [7:0] LeadE1 = 8'hE1;
  localparam logic [6:0] CharQuery = 7'h3F;
  localparam logic [6:0] CaseOffset = 7'h20;
  localparam logic [15:0] CpFirst = 16'h1EA0;
  localparam logic [15:0] CpLast = 16'h1EF9;

  // one queued request: up to two result characters
  typedef struct packed {
    logic       two;
    logic [6:0] c0;
    logic       h0;
    logic [6:0] c1;
    logic       last;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // outcome of decoding a byte that starts a new character
  typedef struct packed {
    logic       res;
    logic [6:0] ch;
    logic       hold;
    logic       skip;
  } fresh_t;

  function automatic logic is_lead(input logic [7:0] b);
    is_lead = (b == LeadC3) || (b == LeadC4) || (b == LeadC6) || (b == LeadE1);
  endfunction

  function automatic fresh_t decode_fresh(input logic [7:0] b, input logic last);
    fresh_t f;
    f = '0;
    if (!b[7]) begin
      f.res = 1'b1;
      f.ch  = b[6:0];
    end else if (is_lead(b)) begin
      if (last) begin
        f.res = 1'b1;
        f.ch  = CharQuery;
      end else begin
        f.hold = 1'b1;
      end
    end else begin
      f.res  = 1'b1;
      f.ch   = CharQuery;
      f.skip = 1'b1;
    end
    return f;
  endfunction

  function automatic logic [6:0] map_pair(input logic [7:0] lead, input logic [7:0] b);
    logic [6:0] c;
    c = CharQuery;
    if (lead == LeadC3) begin
      unique case (b) inside
        [8'h80:8'h85]: c = 7'h41;
        [8'hA0:8'hA5]: c = 7'h61;
        [8'h88:8'h8B]: c = 7'h45;
        [8'hA8:8'hAB]: c = 7'h65;
        [8'h8C:8'h8F]: c = 7'h49;
        [8'hAC:8'hAF]: c = 7'h69;
        [8'h92:8'h96]: c = 7'h4F;
        [8'hB2:8'hB6]: c = 7'h6F;
        [8'h99:8'h9C]: c = 7'h55;
        [8'hB9:8'hBC]: c = 7'h75;
        8'h9D:         c = 7'h59;
        8'hBD, 8'hBF:  c = 7'h79;
        default:       c = CharQuery;
      endcase
    end else if (lead == LeadC4) begin
      unique case (b)
        8'h82:   c = 7'h41;
        8'h83:   c = 7'h61;
        8'h90:   c = 7'h44;
        8'h91:   c = 7'h64;
        default: c = CharQuery;
      endcase
    end else if (lead == LeadC6) begin
      unique case (b)
        8'hA0:   c = 7'h4F;
        8'hA1:   c = 7'h6F;
        8'hAF:   c = 7'h55;
        8'hB0:   c = 7'h75;
        default: c = CharQuery;
      endcase
    end
    return c;
  endfunction

  function automatic logic [6:0] map_triple(input logic [7:0] b2, input logic [7:0] b3);
    logic [15:0] cp;
    logic [6:0]  base;
    logic        known;
    cp = {(LeadE1[3:0]), b2[5:0], b3[5:0]};
    known = 1'b1;
    base = CharQuery;
    if (cp < CpFirst || cp > CpLast) known = 1'b0;
    else if (cp <= 16'h1EB7) base = 7'h41;
    else if (cp <= 16'h1EC7) base = 7'h45;
    else if (cp <= 16'h1ECB) base = 7'h49;
    else if (cp <= 16'h1EE3) base = 7'h4F;
    else if (cp <= 16'h1EF1) base = 7'h55;
    else base = 7'h59;
    if (!known) return CharQuery;
    return cp[0] ? base + CaseOffset : base;
  endfunction

endpackage
`default_nettype wire

FILE: src/u8va_front.sv
// front end: takes input bytes, tracks sequence state, queues result requests
// depends on u8va_pkg
`default_nettype none
module u8va_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_last,
  input  wire u8va_pkg::q_status_t q_status,
  output logic                    push,
  output u8va_pkg::entry_t        entry
);

  logic [7:0] lead_byte, lead_byte_next;
  logic [7:0] second_byte, second_byte_next;
  logic [1:0] bytes_held, bytes_held_next;
  logic       skipping, skipping_next;
  logic       accept, cont, r0_v;
  u8va_pkg::fresh_t f;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign cont     = (in_byte[7:6] == 2'b10);

  always_comb begin
    lead_byte_next   = lead_byte;
    second_byte_next = second_byte;
    bytes_held_next  = bytes_held;
    skipping_next    = skipping;
    r0_v             = 1'b0;
    entry            = '0;
    f                = u8va_pkg::decode_fresh(in_byte, in_last);
    if (bytes_held == 2'd1 && lead_byte != u8va_pkg::LeadE1) begin
      r0_v            = 1'b1;
      entry.c0        = u8va_pkg::map_pair(lead_byte, in_byte);
      entry.h0        = 1'b1;
      bytes_held_next = 2'd0;
    end else if (bytes_held == 2'd1) begin
      if (!in_last) begin
        second_byte_next = in_byte;
        bytes_held_next  = 2'd2;
      end else begin
        r0_v            = 1'b1;
        entry.c0        = u8va_pkg::CharQuery;
        entry.h0        = 1'b1;
        bytes_held_next = 2'd0;
        // a non-continuation final byte is decoded afresh, always yielding a char
        if (!cont) begin
          entry.two = 1'b1;
          entry.c1  = f.ch;
        end
      end
    end else if (bytes_held != 2'd0) begin
      r0_v            = 1'b1;
      entry.c0        = u8va_pkg::map_triple(second_byte, in_byte);
      entry.h0        = 1'b1;
      bytes_held_next = 2'd0;
    end else if (!(skipping && cont)) begin
      r0_v          = f.res;
      entry.c0      = f.ch;
      entry.h0      = f.res;
      skipping_next = f.skip;
      if (f.hold) begin
        lead_byte_next  = in_byte;
        bytes_held_next = 2'd1;
      end
    end
    if (in_last) begin
      // bare end mark when the final byte gives nothing
      if (!r0_v) begin
        r0_v     = 1'b1;
        entry.c0 = '0;
        entry.h0 = 1'b0;
      end
      entry.last       = 1'b1;
      lead_byte_next   = '0;
      second_byte_next = '0;
      bytes_held_next  = '0;
      skipping_next    = 1'b0;
    end
  end

  assign push = accept && r0_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_byte   <= '0;
      second_byte <= '0;
      bytes_held  <= '0;
      skipping    <= 1'b0;
    end else if (accept) begin
      lead_byte   <= lead_byte_next;
      second_byte <= second_byte_next;
      bytes_held  <= bytes_held_next;
      skipping    <= skipping_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/u8va_queue.sv
// short request queue between the front and back ends
// depends on u8va_pkg
`default_nettype none
module u8va_queue #(
  parameter int Depth = u8va_pkg::QueueDepthDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire u8va_pkg::entry_t    wr_entry,
  input  wire logic                pop,
  output u8va_pkg::entry_t         rd_entry,
  output u8va_pkg::q_status_t      status
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  u8va_pkg::entry_t slots [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign status.full  = (count == CntW'(Depth));
  assign status.empty = (count == '0);
  assign rd_entry     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: src/u8va_back.sv
// back end: output register, sends one or two results per queued request
// depends on u8va_pkg
`default_nettype none
module u8va_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire u8va_pkg::entry_t    rd_entry,
  input  wire u8va_pkg::q_status_t q_status,
  output logic                     pop,
  output logic                     m_valid,
  input  wire logic                m_ready,
  output logic [6:0]               m_char,
  output logic                     m_has,
  output logic                     m_last
);

  u8va_pkg::entry_t cur;
  logic phase;
  logic take, finish, load;

  assign take   = m_valid && m_ready;
  assign finish = take && (phase || !cur.two);
  assign load   = !m_valid || finish;
  assign pop    = load && !q_status.empty;

  assign m_char = phase ? cur.c1 : cur.c0;
  assign m_has  = phase ? 1'b1 : cur.h0;
  assign m_last = cur.last && (phase || !cur.two);

  always_ff @(posedge clk) begin
    if (load) cur <= rd_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      phase   <= 1'b0;
    end else if (load) begin
      m_valid <= !q_status.empty;
      phase   <= 1'b0;
    end else if (take) begin
      phase <= 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: src/utf8_vietnamese_to_ascii_top.sv
// top level of the utf-8 vietnamese to ascii stripper
// depends on u8va_pkg, u8va_front, u8va_queue, u8va_back and the macros header
`default_nettype none
`include "utf8_vietnamese_to_ascii_top_macros.svh"
// Takes a UTF-8 string one byte per beat on the slave stream (tlast marks the
// final byte) and sends plain ASCII on the master stream. ASCII passes through,
// the Vietnamese letters of the C3, C4, C6 two-byte and E1 three-byte forms
// become their base letters, and anything unknown becomes '?'. A byte is taken
// every cycle while the request queue has room; the front end decides in the
// same cycle what the byte yields and queues it, and the back end sends one
// result per cycle from its output register while the sink is ready. A byte
// that yields two results (an E1 lead cut short by a final non-continuation
// byte) holds the back end for both, so the sustained rate is one byte per
// cycle except after such bytes. When the final byte yields no character a
// bare end mark is sent: tuser low, tdata zero, tlast high.
module utf8_vietnamese_to_ascii_top #(
  parameter int QUEUE_DEPTH = u8va_pkg::QueueDepthDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // in_byte [7:0]
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // out_char [6:0], zero [7]
  output logic            m_axis_tuser,   // has_char [0]
  output logic            m_axis_tlast
);

  // request handshake between front end and queue, queue and back end
  logic                q_push, q_pop;
  u8va_pkg::entry_t    q_wr, q_rd;
  u8va_pkg::q_status_t q_status;
  logic [6:0]          out_char;

  u8va_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .q_status (q_status),
    .push     (q_push),
    .entry    (q_wr)
  );

  u8va_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_wr),
    .pop      (q_pop),
    .rd_entry (q_rd),
    .status   (q_status)
  );

  u8va_back u_back (
    .clk      (clk),
    .rst      (rst),
    .rd_entry (q_rd),
    .q_status (q_status),
    .pop      (q_pop),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_char   (out_char),
    .m_has    (m_axis_tuser),
    .m_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_char};

  // never write into a full queue, never read an empty one
  `U8VA_ASSERT_SAME(a_push_not_full, clk, rst, q_push, !q_status.full)
  `U8VA_ASSERT_SAME(a_pop_not_empty, clk, rst, q_pop, !q_status.empty)
  // a result without a character is only ever the end mark, and carries zero
  `U8VA_ASSERT_SAME(a_bare_is_last, clk, rst, m_axis_tvalid && !m_axis_tuser,
                    m_axis_tlast && (m_axis_tdata == 8'h00))
  // a push into an empty queue leaves it non-empty unless popped meanwhile
  `U8VA_ASSERT_NEXT(a_push_fills, clk, rst, q_push && q_status.empty,
                    !q_status.empty || $past(q_pop) || q_pop || m_axis_tvalid)

endmodule
`default_nettype wire

FILE: verif/utf8_vietnamese_to_ascii_top_tb.sv
// self-checking testbench for the utf-8 vietnamese to ascii stripper
// drives utf-8 strings, predicts the ascii results and compares them beat by beat
// depends on u8va_pkg and utf8_vietnamese_to_ascii_top
`default_nettype none
module utf8_vietnamese_to_ascii_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomBytes = 1300;
  localparam int TailBytes = 150;    // last part of the run runs with no idling
  localparam int StallLimit = 2000;  // cycles with no handshake before giving up
  localparam int DrainCycles = 10;   // extra wait once all predictions are met

  // one byte request on the slave side
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } utf8_req_t;

  // one result on the master side
  typedef struct packed {
    logic [6:0] ch;
    logic       has;
    logic       last;
  } ascii_res_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       m_axis_tlast;

  utf8_req_t  utf8_bytes[$];     // requests waiting to be driven
  ascii_res_t expected_chars[$]; // predicted results, oldest first
  ascii_res_t step_chars[$];     // results of the request being decoded

  // decoder state as predicted
  logic [7:0] held_lead;
  logic [7:0] held_second;
  logic [1:0] held_count;
  logic       dropping;

  int errors = 0;
  int total_bytes = 0;
  int bytes_accepted = 0;
  int send_gap = 0;
  int sink_gap = 0;
  int idle_cycles = 0;
  logic calm;
  utf8_req_t next_req;
  ascii_res_t got;

  utf8_vietnamese_to_ascii_top dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idling stops once only the tail of the stimulus is left
  assign calm = (bytes_accepted + TailBytes >= total_bytes);

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic ascii_res_t char_res(input logic [7:0] c);
    ascii_res_t r;
    r.ch = c[6:0];
    r.has = 1'b1;
    r.last = 1'b0;
    return r;
  endfunction

  // base letter of a two-byte latin-1 or latin extended form
  function automatic logic [7:0] pair_letter(input logic [7:0] lead, input logic [7:0] b);
    logic [7:0] c;
    c = {1'b0, u8va_pkg::CharQuery};
    if (lead == u8va_pkg::LeadC3) begin
      if (b inside {[8'h80:8'h85]}) c = "A";
      else if (b inside {[8'hA0:8'hA5]}) c = "a";
      else if (b inside {[8'h88:8'h8B]}) c = "E";
      else if (b inside {[8'hA8:8'hAB]}) c = "e";
      else if (b inside {[8'h8C:8'h8F]}) c = "I";
      else if (b inside {[8'hAC:8'hAF]}) c = "i";
      else if (b inside {[8'h92:8'h96]}) c = "O";
      else if (b inside {[8'hB2:8'hB6]}) c = "o";
      else if (b inside {[8'h99:8'h9C]}) c = "U";
      else if (b inside {[8'hB9:8'hBC]}) c = "u";
      else if (b == 8'h9D) c = "Y";
      else if (b == 8'hBD || b == 8'hBF) c = "y";
    end else if (lead == u8va_pkg::LeadC4) begin
      if (b == 8'h82) c = "A";
      else if (b == 8'h83) c = "a";
      else if (b == 8'h90) c = "D";
      else if (b == 8'h91) c = "d";
    end else if (lead == u8va_pkg::LeadC6) begin
      if (b == 8'hA0) c = "O";
      else if (b == 8'hA1) c = "o";
      else if (b == 8'hAF) c = "U";
      else if (b == 8'hB0) c = "u";
    end
    return c;
  endfunction

  // base letter of a three-byte form in the vietnamese extended block
  function automatic logic [7:0] triple_letter(input logic [7:0] b2, input logic [7:0] b3);
    logic [15:0] cp;
    logic [7:0]  c;
    cp = {u8va_pkg::LeadE1[3:0], b2[5:0], b3[5:0]};
    if (cp < u8va_pkg::CpFirst || cp > u8va_pkg::CpLast) return {1'b0, u8va_pkg::CharQuery};
    if (cp <= 16'h1EB7) c = "A";
    else if (cp <= 16'h1EC7) c = "E";
    else if (cp <= 16'h1ECB) c = "I";
    else if (cp <= 16'h1EE3) c = "O";
    else if (cp <= 16'h1EF1) c = "U";
    else c = "Y";
    // odd code points are the lower-case forms
    return cp[0] ? c + {1'b0, u8va_pkg::CaseOffset} : c;
  endfunction

  // a byte with no sequence pending
  task automatic start_char(input logic [7:0] b, input logic fin);
    dropping = 1'b0;
    if (!b[7]) begin
      step_chars.push_back(char_res(b));
    end else if (b == u8va_pkg::LeadC3 || b == u8va_pkg::LeadC4 ||
                 b == u8va_pkg::LeadC6 || b == u8va_pkg::LeadE1) begin
      if (fin) begin
        step_chars.push_back(char_res({1'b0, u8va_pkg::CharQuery}));
      end else begin
        held_lead = b;
        held_count = 2'd1;
      end
    end else begin
      // unknown byte: flag it and drop the continuation bytes after it
      dropping = 1'b1;
      step_chars.push_back(char_res({1'b0, u8va_pkg::CharQuery}));
    end
  endtask

  task automatic clear_state();
    held_lead = 8'h00;
    held_second = 8'h00;
    held_count = 2'd0;
    dropping = 1'b0;
  endtask

  // predict the results of one accepted request
  task automatic decode_step(input logic [7:0] b, input logic fin);
    logic cont;
    ascii_res_t mark;
    cont = (b[7:6] == 2'b10);
    step_chars.delete();
    if (held_count == 2'd1 && held_lead != u8va_pkg::LeadE1) begin
      step_chars.push_back(char_res(pair_letter(held_lead, b)));
      held_count = 2'd0;
    end else if (held_count == 2'd1) begin
      if (!fin) begin
        held_second = b;
        held_count = 2'd2;
        return;
      end
      // e1 cut short by the final byte
      step_chars.push_back(char_res({1'b0, u8va_pkg::CharQuery}));
      held_count = 2'd0;
      if (!cont) start_char(b, fin);
    end else if (held_count >= 2'd2) begin
      step_chars.push_back(char_res(triple_letter(held_second, b)));
      held_count = 2'd0;
    end else if (!(dropping && cont)) begin
      start_char(b, fin);
    end
    if (fin) begin
      if (step_chars.size() == 0) begin
        mark = '0;
        step_chars.push_back(mark);
      end
      step_chars[step_chars.size() - 1].last = 1'b1;
      clear_state();
    end
    foreach (step_chars[i]) expected_chars.push_back(step_chars[i]);
  endtask

  task automatic add_byte(input logic [7:0] b, input logic fin);
    utf8_req_t r;
    r.data = b;
    r.fin = fin;
    utf8_bytes.push_back(r);
    total_bytes++;
  endtask

  task automatic add_string(input int len);
    logic [7:0] seq[$];
    logic [15:0] cp;
    int kind;
    seq.delete();
    while (seq.size() < len) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        seq.push_back(8'($urandom_range(0, 127)));
      end else if (kind < 55) begin
        seq.push_back(u8va_pkg::LeadC3);
        seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (kind < 62) begin
        seq.push_back($urandom_range(0, 1) ? u8va_pkg::LeadC4 : u8va_pkg::LeadC6);
        case ($urandom_range(0, 5))
          0: seq.push_back(8'h82);
          1: seq.push_back(8'h91);
          2: seq.push_back(8'hA0);
          3: seq.push_back(8'hB0);
          default: seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
        endcase
      end else if (kind < 78) begin
        // mostly inside the mapped block, sometimes just around it
        if ($urandom_range(0, 4) == 0) cp = 16'h1E00 + 16'($urandom_range(0, 255));
        else cp = u8va_pkg::CpFirst + 16'($urandom_range(0, 16'h59));
        seq.push_back(u8va_pkg::LeadE1);
        seq.push_back({2'b10, cp[11:6]});
        seq.push_back({2'b10, cp[5:0]});
      end else if (kind < 86) begin
        // a lead followed by anything at all
        case ($urandom_range(0, 3))
          0: seq.push_back(u8va_pkg::LeadC3);
          1: seq.push_back(u8va_pkg::LeadC4);
          2: seq.push_back(u8va_pkg::LeadC6);
          default: seq.push_back(u8va_pkg::LeadE1);
        endcase
        seq.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 92) begin
        // stray high byte with one trailing continuation byte
        seq.push_back(8'($urandom_range(8'h80, 8'hFF)));
        seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else begin
        seq.push_back(8'($urandom_range(0, 255)));
      end
    end
    // the string ends at len, which may cut a sequence short
    for (int i = 0; i < len; i++) add_byte(seq[i], i == len - 1);
  endtask

  // stimulus and end of run
  initial begin
    clear_state();
    // directed part
    add_byte(8'h00, 1'b0);
    add_byte(8'h7F, 1'b1);         // plain ascii extremes
    add_byte(u8va_pkg::LeadC3, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(u8va_pkg::LeadC3, 1'b0); add_byte(8'hBF, 1'b0);
    add_byte(u8va_pkg::LeadC4, 1'b0); add_byte(8'h90, 1'b0);
    add_byte(u8va_pkg::LeadC6, 1'b0); add_byte(8'hB0, 1'b0);
    // non-continuation after lead
    add_byte(u8va_pkg::LeadC3, 1'b0); add_byte(8'h41, 1'b1);
    // first letter
    add_byte(u8va_pkg::LeadE1, 1'b0); add_byte(8'hBA, 1'b0); add_byte(8'hA0, 1'b0);
    // last letter
    add_byte(u8va_pkg::LeadE1, 1'b0); add_byte(8'hBB, 1'b0); add_byte(8'hB9, 1'b0);
    // past the block
    add_byte(u8va_pkg::LeadE1, 1'b0); add_byte(8'hBB, 1'b0); add_byte(8'hBA, 1'b1);
    // e1 cut short, final byte decoded
    add_byte(u8va_pkg::LeadE1, 1'b0); add_byte(8'h78, 1'b1);
    // e1 cut short, final byte dropped
    add_byte(u8va_pkg::LeadE1, 1'b0); add_byte(8'h80, 1'b1);
    // cut short, then lead as final byte
    add_byte(u8va_pkg::LeadE1, 1'b0); add_byte(u8va_pkg::LeadC3, 1'b1);
    add_byte(8'hFF, 1'b0); add_byte(8'h80, 1'b0); add_byte(8'h61, 1'b1); // skip then ascii
    add_byte(8'hF0, 1'b0); add_byte(8'hBF, 1'b1);    // skipped final byte gives bare mark
    add_byte(u8va_pkg::LeadE1, 1'b1);                 // lead as final byte
    // random strings, mostly well formed
    while (total_bytes < RandomBytes) add_string($urandom_range(1, 12));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (utf8_bytes.size() != 0 || s_axis_tvalid || expected_chars.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // driver: holds each request until taken, gaps only between requests
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_step(s_axis_tdata, s_axis_tlast);
        bytes_accepted <= bytes_accepted + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (utf8_bytes.size() != 0) begin
          next_req = utf8_bytes.pop_front();
          s_axis_tdata <= next_req.data;
          s_axis_tlast <= next_req.fin;
          s_axis_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 3);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result against the oldest prediction and stalls at random
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("result with nothing predicted: data %h user %b last %b",
                                    m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end else begin
          got = expected_chars.pop_front();
          if (m_axis_tdata !== {1'b0, got.ch})
            report_mismatch($sformatf("out_char %h, predicted %h", m_axis_tdata, got.ch));
          if (m_axis_tuser !== got.has)
            report_mismatch($sformatf("has_char %b, predicted %b", m_axis_tuser, got.has));
          if (m_axis_tlast !== got.last)
            report_mismatch($sformatf("out_last %b, predicted %b", m_axis_tlast, got.last));
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        // stall burst of random length
        sink_gap = $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles in which neither side moves a request
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("ERROR: no handshake for %0d cycles", StallLimit);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
`default_nettype wire
